// ----- sv/seqm_pkg.sv -----
// ----------------------------------------------------------------------------
// seqm_pkg: shared types and constants
// Request codes, cell commands, controller states, fixed port widths and
// parameter defaults for the sequence move and range count block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package seqm_pkg;

  // Fixed port widths
  localparam int REQ_W = 2;
  localparam int POS_W = 11;
  localparam int KEY_W = 10;
  localparam int CNT_W = 11;

  // Parameter defaults
  localparam int MAX_LEN_DEF     = 1024;
  localparam int VALUE_WIDTH_DEF = 10;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_MOVE   = 2'd1,
    REQ_COUNT  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SWAP,
    CELL_MARK,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_SHIFT,
    ST_RESULT
  } ctrl_state_e;

endpackage

`default_nettype wire

// ----- sv/seqm_cell.sv -----
// ----------------------------------------------------------------------------
// seqm_cell: one sequence position
// Holds one element and one match flag. Writes, swaps with a neighbor, marks
// a match and shifts the flag toward the head, as the broadcast command says.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seqm_cell
  import seqm_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int IDX_W       = 10,
  parameter int INDEX       = 0
) (
  input  wire                   clk_i,
  input  cell_op_e              cmd_i,
  input  wire [IDX_W-1:0]       lo_i,
  input  wire [IDX_W-1:0]       hi_i,
  input  wire [VALUE_WIDTH-1:0] key_i,
  input  wire [VALUE_WIDTH-1:0] left_val_i,
  input  wire [VALUE_WIDTH-1:0] right_val_i,
  input  wire                   right_flag_i,
  output logic [VALUE_WIDTH-1:0] val_o,
  output logic                  flag_o
);

  localparam logic [IDX_W-1:0] IndexC = IDX_W'(INDEX);

  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic                   flag_q, flag_d;

  always_comb begin
    val_d  = val_q;
    flag_d = flag_q;
    case (cmd_i)
      CELL_WRITE: begin
        if (lo_i == IndexC) val_d = key_i;
      end
      CELL_SWAP: begin
        // lo and hi name the two neighbors that trade places
        if (lo_i == IndexC) begin
          val_d = right_val_i;
        end else if (hi_i == IndexC) begin
          val_d = left_val_i;
        end
      end
      CELL_MARK: begin
        flag_d = (IndexC >= lo_i) && (IndexC <= hi_i) && (val_q == key_i);
      end
      CELL_SHIFT: begin
        flag_d = right_flag_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    flag_q <= flag_d;
  end

  assign val_o  = val_q;
  assign flag_o = flag_q;

endmodule

`default_nettype wire

// ----- sv/seqm_ctrl.sv -----
// ----------------------------------------------------------------------------
// seqm_ctrl: request sequencer
// Decodes requests, keeps the sequence length, steps the neighbor swaps of a
// move, drains match flags for a count and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seqm_ctrl
  import seqm_pkg::*;
#(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int IDX_W       = $clog2(MAX_LEN)
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire [REQ_W-1:0]        req_type_i,
  input  wire [POS_W-1:0]        first_pos_i,
  input  wire [POS_W-1:0]        second_pos_i,
  input  wire [KEY_W-1:0]        key_value_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output logic [CNT_W-1:0]       match_count_o,
  input  wire                    head_flag_i,
  output cell_op_e               cmd_o,
  output logic [IDX_W-1:0]       lo_o,
  output logic [IDX_W-1:0]       hi_o,
  output logic [VALUE_WIDTH-1:0] key_o
);

  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int CMP_W   = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int CMP_X_W = (CMP_W > CNT_W) ? CMP_W : CNT_W;
  localparam int KEY_X_W = (VALUE_WIDTH > KEY_W) ? VALUE_WIDTH : KEY_W;

  ctrl_state_e      state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] stop_q, stop_d;
  logic             up_q, up_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [LEN_W-1:0] acc_q, acc_d;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] out_cnt_q, out_cnt_d;

  logic [CMP_W-1:0]   l_x, r_x, len_x, li_x, ri_x;
  logic [IDX_W-1:0]   li, ri;
  logic               l_ok, r_ok;
  logic [KEY_X_W-1:0] key_x;
  logic [CMP_X_W-1:0] acc_x;

  assign l_x   = CMP_W'(first_pos_i);
  assign r_x   = CMP_W'(second_pos_i);
  assign len_x = CMP_W'(len_q);
  assign li_x  = l_x - 1'b1;
  assign ri_x  = r_x - 1'b1;
  assign li    = li_x[IDX_W-1:0];
  assign ri    = ri_x[IDX_W-1:0];
  assign l_ok  = (l_x != '0) && (l_x <= len_x);
  assign r_ok  = (r_x != '0) && (r_x <= len_x);
  assign key_x = KEY_X_W'(key_value_i);
  assign key_o = key_x[VALUE_WIDTH-1:0];
  assign acc_x = CMP_X_W'(acc_q);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    j_d         = j_q;
    stop_d      = stop_q;
    up_d        = up_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_cnt_d   = out_cnt_q;
    cmd_o       = CELL_HOLD;
    lo_o        = '0;
    hi_o        = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (req_type_i)
            REQ_APPEND: begin
              if (len_x < CMP_W'(MAX_LEN)) begin
                cmd_o = CELL_WRITE;
                lo_o  = len_x[IDX_W-1:0];
                len_d = len_q + 1'b1;
              end
            end
            REQ_MOVE: begin
              if (l_ok && r_ok) begin
                // walk the element from r toward l by adjacent swaps
                if (li < ri) begin
                  j_d     = ri - 1'b1;
                  stop_d  = li;
                  up_d    = 1'b0;
                  state_d = ST_MOVE;
                end else if (li > ri) begin
                  j_d     = ri;
                  stop_d  = li - 1'b1;
                  up_d    = 1'b1;
                  state_d = ST_MOVE;
                end
              end
            end
            REQ_COUNT: begin
              acc_d = '0;
              if (l_ok && r_ok && (l_x <= r_x)) begin
                cmd_o   = CELL_MARK;
                lo_o    = li;
                hi_o    = ri;
                rem_d   = r_x[LEN_W-1:0];
                state_d = ST_SHIFT;
              end else begin
                state_d = ST_RESULT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MOVE: begin
        cmd_o = CELL_SWAP;
        lo_o  = j_q;
        hi_o  = j_q + 1'b1;
        if (j_q == stop_q) begin
          state_d = ST_IDLE;
        end else begin
          j_d = up_q ? (j_q + 1'b1) : (j_q - 1'b1);
        end
      end
      ST_SHIFT: begin
        // position 1 flag sits in cell 0; shift r flags through it
        cmd_o = CELL_SHIFT;
        acc_d = acc_q + LEN_W'(head_flag_i);
        rem_d = rem_q - 1'b1;
        if (rem_q == LEN_W'(1)) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_cnt_d   = acc_x[CNT_W-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q       <= j_d;
    stop_q    <= stop_d;
    up_q      <= up_d;
    rem_q     <= rem_d;
    acc_q     <= acc_d;
    out_cnt_q <= out_cnt_d;
  end

  assign out_valid_o   = out_valid_q;
  assign match_count_o = out_cnt_q;

endmodule

`default_nettype wire

// ----- sv/sequence_move_and_range_count_top.sv -----
// ----------------------------------------------------------------------------
// sequence_move_and_range_count_top: ordered sequence with move and count
// Requests arrive on a valid/ready input channel: append, move, count. Only
// a count produces a transaction on the valid/ready output channel.
//
// The sequence lives in a row of MAX_LEN cells, one element per cell.
// Steps per request, from acceptance:
//   append        the addressed cell loads the value
//   move l, r     one adjacent swap per cycle, walking the element from r to l
//   count l..r    every cell marks its match at once on acceptance, then the
//                 flags of positions 1..r drain one per cycle through the head
//                 cell into the counter, then the result is registered
// Ignored requests (out of range, full, unused code) change nothing; an
// out-of-range or reversed count still returns 0.
// One request is in work at a time. The result sits in an output register,
// so appends and moves are accepted while a count result waits; a further
// count holds at the result step until the receiver takes the old one.
// Reset empties the sequence and drops any pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sequence_move_and_range_count_top
  import seqm_pkg::*;
#(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire [REQ_W-1:0]  req_type_i,
  input  wire [POS_W-1:0]  first_pos_i,
  input  wire [POS_W-1:0]  second_pos_i,
  input  wire [KEY_W-1:0]  key_value_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output logic [CNT_W-1:0] match_count_o
);

  localparam int IDX_W = $clog2(MAX_LEN);

  cell_op_e               cmd;
  logic [IDX_W-1:0]       lo, hi;
  logic [VALUE_WIDTH-1:0] key;
  logic [VALUE_WIDTH-1:0] vals  [MAX_LEN];
  logic                   flags [MAX_LEN];

  seqm_ctrl #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_WIDTH(VALUE_WIDTH),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .first_pos_i  (first_pos_i),
    .second_pos_i (second_pos_i),
    .key_value_i  (key_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .match_count_o(match_count_o),
    .head_flag_i  (flags[0]),
    .cmd_o        (cmd),
    .lo_o         (lo),
    .hi_o         (hi),
    .key_o        (key)
  );

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_val, right_val;
    logic                   right_flag;

    if (i == 0) begin : g_head
      assign left_val = '0;
    end else begin : g_mid
      assign left_val = vals[i-1];
    end

    if (i == MAX_LEN - 1) begin : g_tail
      assign right_val  = '0;
      assign right_flag = 1'b0;
    end else begin : g_body
      assign right_val  = vals[i+1];
      assign right_flag = flags[i+1];
    end

    seqm_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .lo_i        (lo),
      .hi_i        (hi),
      .key_i       (key),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .right_flag_i(right_flag),
      .val_o       (vals[i]),
      .flag_o      (flags[i])
    );
  end

endmodule

`default_nettype wire

// ----- sv/seqm_checker.sv -----
// ----------------------------------------------------------------------------
// seqm_checker: port-level checks
// Watches the top level ports: output hold under stall, count range and
// busy/ready behavior around accepted requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seqm_checker
  import seqm_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input wire             clk_i,
  input wire             rst_ni,
  input wire             in_valid_i,
  input wire             in_ready_o,
  input wire [REQ_W-1:0] req_type_i,
  input wire             out_valid_o,
  input wire             out_ready_i,
  input wire [CNT_W-1:0] match_count_o
);

  // stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(match_count_o))
    else $error("result changed or dropped while stalled");

  // a count never exceeds the sequence capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(match_count_o) <= MAX_LEN))
    else $error("match count above capacity");

  // ready is low in the cycle after a count is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_i == REQ_COUNT) |=> !in_ready_o)
    else $error("ready right after count transaction");

  // an append finishes in the cycle it is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_i == REQ_APPEND) |=> in_ready_o)
    else $error("not ready after append transaction");

endmodule

bind sequence_move_and_range_count_top seqm_checker #(
  .MAX_LEN(MAX_LEN)
) u_seqm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .req_type_i   (req_type_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .match_count_o(match_count_o)
);

`default_nettype wire
